### sv/rd64_pkg.sv
package rd64_pkg;

    // field widths fixed at the ports
    localparam int unsigned FIELD_W = 64;

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               div_by_zero;
    } t_out_item;

    // selector codes
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic store;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_by_zero;
    } t_dp_status;

endpackage

### sv/rd64_datapath.sv
module rd64_datapath #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  rd64_pkg::t_ctrl_cmd   i_cmd,
    input  rd64_pkg::t_in_item    i_in_item,
    output rd64_pkg::t_dp_status  o_status,
    output rd64_pkg::t_out_item   o_out_item
);

    localparam int DW = DATA_WIDTH;

    logic [DW-1:0] r_num, n_num;   // dividend, quotient bits shift in from the bottom
    logic [DW-1:0] r_den, n_den;
    logic [DW-1:0] r_rem, n_rem;
    logic          r_neg_q, n_neg_q;
    logic          r_neg_r, n_neg_r;
    logic          r_dz, n_dz;
    rd64_pkg::t_out_item r_out, n_out;

    logic [DW-1:0] in_num;
    logic [DW-1:0] in_den;
    logic          num_neg;
    logic          den_neg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] q_fix;
    logic [DW-1:0] r_fix;

    always_comb begin
        in_num  = i_in_item.dividend[DW-1:0];
        in_den  = i_in_item.divisor[DW-1:0];
        num_neg = (i_in_item.op == rd64_pkg::OP_SIGNED) && in_num[DW-1];
        den_neg = (i_in_item.op == rd64_pkg::OP_SIGNED) && in_den[DW-1];

        // one restoring step
        trial = {r_rem, r_num[DW-1]};
        diff  = trial - {1'b0, r_den};

        q_fix = r_neg_q ? (~r_num + {{(DW-1){1'b0}}, 1'b1}) : r_num;
        r_fix = r_neg_r ? (~r_rem + {{(DW-1){1'b0}}, 1'b1}) : r_rem;

        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        n_dz    = r_dz;
        n_out   = r_out;

        if (i_cmd.load) begin
            n_num   = num_neg ? (~in_num + {{(DW-1){1'b0}}, 1'b1}) : in_num;
            n_den   = den_neg ? (~in_den + {{(DW-1){1'b0}}, 1'b1}) : in_den;
            n_rem   = '0;
            n_neg_q = num_neg ^ den_neg;
            n_neg_r = num_neg;
            n_dz    = (in_den == '0);
        end else if (i_cmd.step) begin
            if (!diff[DW]) begin
                n_rem = diff[DW-1:0];
                n_num = {r_num[DW-2:0], 1'b1};
            end else begin
                n_rem = trial[DW-1:0];
                n_num = {r_num[DW-2:0], 1'b0};
            end
        end

        if (i_cmd.store) begin
            n_out = '0;
            n_out.div_by_zero = r_dz;
            if (!r_dz) begin
                n_out.quotient[DW-1:0]  = q_fix;
                n_out.remainder[DW-1:0] = r_fix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_den   <= n_den;
        r_rem   <= n_rem;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_dz    <= n_dz;
        r_out   <= n_out;
    end

    assign o_status.div_by_zero = r_dz;
    assign o_out_item           = r_out;

endmodule

### sv/rd64_ctrl.sv
module rd64_ctrl #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  rd64_pkg::t_dp_status  i_status,
    output rd64_pkg::t_ctrl_cmd   o_cmd
);

    localparam int CW = $clog2(DATA_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    logic          slot_free;

    always_comb begin
        slot_free   = !r_out_valid || i_out_ready;
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_count    = CW'(DATA_WIDTH - 1);
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.div_by_zero) begin
                    n_state = ST_FIX;
                end else begin
                    o_cmd.step = 1'b1;
                    n_count    = r_count - {{(CW-1){1'b0}}, 1'b1};
                    if (r_count == '0) begin
                        n_state = ST_FIX;
                    end
                end
            end
            ST_FIX: begin
                if (slot_free) begin
                    o_cmd.store = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### sv/restoring_divider_64_top.sv
// radix-2 restoring integer divider, unsigned or signed (two's complement,
// truncating toward zero, remainder carries the dividend's sign); only the
// low DATA_WIDTH bits of each operand are used and results are zero above
// them; a zero divisor gives div_by_zero with zero quotient and remainder,
// and the most negative value over minus one wraps; an input beat is taken
// only while the unit is idle; the unit then loads and makes the operands
// positive, makes one quotient bit per cycle through the single shared
// subtractor, and does the sign fix-up into the output register, which waits
// while the output register still holds an unaccepted result; a new beat is
// not taken before the last one is through the fix-up; a zero divisor skips
// the bit loop; the output register lets the next beat be taken while a
// finished result still waits
module restoring_divider_64_top #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // operand beats
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rd64_pkg::t_in_item  i_in_item,
    // result beats
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rd64_pkg::t_out_item o_out_item
);

    // command and status between controller and datapath
    rd64_pkg::t_ctrl_cmd  cmd;
    rd64_pkg::t_dp_status status;

    // sequencer: idle, bit loop, fix-up and hand-off
    rd64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // operand registers, subtractor, sign fix-up and output register
    rd64_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule
